// ===== rtl/nha_pkg.sv =====
// ----------------------------------------------------------------------------
// nha_pkg: shared types and constants for the nearest head assignment block
// Field widths, queue depth, distance limit and the command word passed
// from the front end to the search engine.
// ----------------------------------------------------------------------------
package nha_pkg;

  // default parameter values
  localparam int MAX_HEADS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int FIELD_COORD_BITS = 16;
  localparam int NODE_BITS        = 8;
  localparam int SLOT_BITS        = 4;
  localparam int COUNT_BITS       = 5;

  // depth of the command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // a head counts only if its squared distance is below this limit
  localparam int                    LIMIT_BITS   = 40;
  localparam logic [LIMIT_BITS-1:0] FAR_LIMIT_SQ = 40'd1000000000000;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // classified word handed to the search engine
  typedef struct packed {
    mode_t                       mode;
    logic                        is_head;
    logic [SLOT_BITS-1:0]        slot;
    logic [FIELD_COORD_BITS-1:0] x;
    logic [FIELD_COORD_BITS-1:0] y;
    logic [NODE_BITS-1:0]        node;
  } cmd_t;

endpackage

// ===== rtl/nha_if.sv =====
// ----------------------------------------------------------------------------
// nha_if: valid/ready channels of the nearest head assignment block
// Input word channel, result word channel and head count write channel.
// ----------------------------------------------------------------------------
interface nha_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic [nha_pkg::SLOT_BITS-1:0]        entry_index;
  logic [nha_pkg::FIELD_COORD_BITS-1:0] point_x;
  logic [nha_pkg::FIELD_COORD_BITS-1:0] point_y;
  logic [nha_pkg::NODE_BITS-1:0]        node_number;
  logic                                 is_head;

  modport source (output valid, mode, entry_index, point_x, point_y, node_number, is_head,
                  input ready);
  modport sink   (input valid, mode, entry_index, point_x, point_y, node_number, is_head,
                  output ready);
endinterface

interface nha_out_if;
  logic                          valid;
  logic                          ready;
  logic [nha_pkg::NODE_BITS-1:0] queried_node;
  logic [nha_pkg::NODE_BITS-1:0] assigned_head;
  logic                          found;

  modport source (output valid, queried_node, assigned_head, found, input ready);
  modport sink   (input valid, queried_node, assigned_head, found, output ready);
endinterface

interface nha_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nha_pkg::COUNT_BITS-1:0] head_count;

  modport source (output valid, head_count, input ready);
  modport sink   (input valid, head_count, output ready);
endinterface

// ===== rtl/nha_ram.sv =====
// ----------------------------------------------------------------------------
// nha_ram: generic single write port, single read port RAM
// Read data is registered; one write and one read per cycle.
// ----------------------------------------------------------------------------
module nha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nha_queue.sv =====
// ----------------------------------------------------------------------------
// nha_queue: short command queue between front end and search engine
// Decouples input acceptance from the multi-cycle search.
// ----------------------------------------------------------------------------
module nha_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nha_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output nha_pkg::cmd_t pop_cmd
);

  localparam int PW = (nha_pkg::QUEUE_DEPTH > 1) ? $clog2(nha_pkg::QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(nha_pkg::QUEUE_DEPTH + 1);

  nha_pkg::cmd_t slots_r [nha_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  assign full      = (fill_r == FW'(nha_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_cmd   = slots_r[rd_ptr_r];

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    fill_nxt   = fill_r + FW'(push) - FW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/nha_front.sv =====
// ----------------------------------------------------------------------------
// nha_front: input acceptance, classification and head count register
// Drops loads aimed past the table, queues all other words.
// ----------------------------------------------------------------------------
module nha_front #(
  parameter int MAX_HEADS = nha_pkg::MAX_HEADS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nha_in_if.sink                         in_ch,
  nha_cfg_if.sink                        cfg_ch,
  input  logic                           q_full,
  output logic                           push,
  output nha_pkg::cmd_t                  push_cmd,
  output logic [nha_pkg::COUNT_BITS-1:0] head_count
);

  logic [nha_pkg::COUNT_BITS-1:0] head_count_r, head_count_nxt;
  logic                           accept;
  logic                           slot_ok;

  // head count register, always writable
  assign cfg_ch.ready   = 1'b1;
  assign head_count_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.head_count : head_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_count_r <= '0;
    end else begin
      head_count_r <= head_count_nxt;
    end
  end

  assign head_count = head_count_r;

  // accept while the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify: keep queries and in-range loads
  assign slot_ok = (32'(in_ch.entry_index) < 32'(MAX_HEADS));

  always_comb begin
    push_cmd.mode    = nha_pkg::mode_t'(in_ch.mode);
    push_cmd.is_head = in_ch.is_head;
    push_cmd.slot    = in_ch.entry_index;
    push_cmd.x       = in_ch.point_x;
    push_cmd.y       = in_ch.point_y;
    push_cmd.node    = in_ch.node_number;
    push             = accept && ((push_cmd.mode == nha_pkg::MODE_QUERY) || slot_ok);
  end

endmodule

// ===== rtl/nha_back.sv =====
// ----------------------------------------------------------------------------
// nha_back: head table and nearest head search engine
// Writes head entries, scans the table one entry a cycle through a
// read / difference / square / compare pipeline, and holds the result word.
// ----------------------------------------------------------------------------
module nha_back #(
  parameter int MAX_HEADS  = nha_pkg::MAX_HEADS_DEF,
  parameter int COORD_BITS = nha_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  nha_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  input  logic [nha_pkg::COUNT_BITS-1:0] head_count,
  nha_out_if.source                      out_ch
);

  localparam int NB   = nha_pkg::NODE_BITS;
  localparam int CW   = (COORD_BITS < nha_pkg::FIELD_COORD_BITS) ?
                        COORD_BITS : nha_pkg::FIELD_COORD_BITS;
  localparam int AW   = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int CNTW = $clog2(MAX_HEADS + 1);
  localparam int SW   = 2 * CW + 1;
  localparam int BW   = (SW > nha_pkg::LIMIT_BITS) ? SW : nha_pkg::LIMIT_BITS;
  localparam int RW   = 2 * CW + NB;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CNTW-1:0] count_lim;
  logic            is_query;
  logic            quick;
  logic            out_free;
  logic            ram_we;
  logic            start_scan;
  logic            quick_load;
  logic            report_load;
  logic            rd_en;
  logic            scan_done;

  // query context
  logic [CNTW-1:0] iss_r, iss_nxt;
  logic [CNTW-1:0] cnt_r;
  logic [CW-1:0]   px_r, py_r;
  logic [NB-1:0]   num_r;

  // table read data
  logic [RW-1:0]   rdata;
  logic [CW-1:0]   rd_x, rd_y;
  logic [NB-1:0]   rd_node;

  // pipeline stages
  logic            v1_r, first1_r;
  logic            vd_r, firstd_r;
  logic [CW-1:0]   dx_r, dy_r;
  logic [NB-1:0]   node_d_r;
  logic            vs_r, firsts_r;
  logic [2*CW-1:0] sqx_r, sqy_r;
  logic [NB-1:0]   node_s_r;
  logic [SW-1:0]   sum;
  logic [BW-1:0]   thresh;
  logic            closer;
  logic [BW-1:0]   best_r;
  logic [NB-1:0]   best_node_r;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [NB-1:0]   out_qnode_r, out_head_r;
  logic            out_found_r;

  // clamp the head count to the table size
  assign count_lim = (32'(head_count) > 32'(MAX_HEADS)) ? CNTW'(MAX_HEADS) : CNTW'(head_count);

  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_query    = (q_cmd.mode == nha_pkg::MODE_QUERY);
  assign quick       = is_query && (q_cmd.is_head || (count_lim == '0));
  assign q_pop       = (state_r == ST_IDLE) && q_valid && (!quick || out_free);
  assign ram_we      = q_pop && !is_query;
  assign start_scan  = q_pop && is_query && !quick;
  assign quick_load  = q_pop && quick;
  assign report_load = (state_r == ST_REPORT) && out_free;

  assign rd_en     = (state_r == ST_SCAN) && (iss_r < cnt_r);
  assign scan_done = (state_r == ST_SCAN) && !rd_en && !v1_r && !vd_r && !vs_r;
  assign iss_nxt   = start_scan ? '0 : (rd_en ? iss_r + CNTW'(1) : iss_r);

  // sequence one query at a time
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start_scan) begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN:   if (scan_done) begin
        state_nxt = ST_REPORT;
      end
      ST_REPORT: if (report_load) begin
        state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= '0;
      v1_r    <= 1'b0;
      vd_r    <= 1'b0;
      vs_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      v1_r    <= rd_en;
      vd_r    <= v1_r;
      vs_r    <= vd_r;
    end
  end

  // latch query context
  always_ff @(posedge clk) begin
    if (start_scan) begin
      cnt_r <= count_lim;
      px_r  <= q_cmd.x[CW-1:0];
      py_r  <= q_cmd.y[CW-1:0];
      num_r <= q_cmd.node;
    end
  end

  // head table
  nha_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_HEADS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_cmd.slot)),
    .wdata ({q_cmd.x[CW-1:0], q_cmd.y[CW-1:0], q_cmd.node}),
    .re    (rd_en),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_x    = rdata[RW-1 -: CW];
  assign rd_y    = rdata[NB +: CW];
  assign rd_node = rdata[NB-1:0];

  // stage: absolute coordinate differences
  always_ff @(posedge clk) begin
    first1_r <= (iss_r == '0);
    firstd_r <= first1_r;
    dx_r     <= (px_r > rd_x) ? px_r - rd_x : rd_x - px_r;
    dy_r     <= (py_r > rd_y) ? py_r - rd_y : rd_y - py_r;
    node_d_r <= rd_node;
  end

  // stage: squares
  always_ff @(posedge clk) begin
    firsts_r <= firstd_r;
    sqx_r    <= dx_r * dx_r;
    sqy_r    <= dy_r * dy_r;
    node_s_r <= node_d_r;
  end

  // stage: sum and keep the first minimum
  assign sum    = SW'(sqx_r) + SW'(sqy_r);
  assign thresh = firsts_r ? BW'(nha_pkg::FAR_LIMIT_SQ) : best_r;
  assign closer = (BW'(sum) < thresh);

  always_ff @(posedge clk) begin
    if (vs_r) begin
      if (closer) begin
        best_r <= BW'(sum);
      end else if (firsts_r) begin
        best_r <= BW'(nha_pkg::FAR_LIMIT_SQ);
      end
      if (closer || firsts_r) begin
        best_node_r <= node_s_r;
      end
    end
  end

  // result word register
  always_comb begin
    if (quick_load || report_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (quick_load) begin
      out_qnode_r <= q_cmd.node;
      out_head_r  <= q_cmd.is_head ? q_cmd.node : '0;
      out_found_r <= q_cmd.is_head;
    end else if (report_load) begin
      out_qnode_r <= num_r;
      out_head_r  <= best_node_r;
      out_found_r <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.queried_node  = out_qnode_r;
  assign out_ch.assigned_head = out_head_r;
  assign out_ch.found         = out_found_r;

endmodule

// ===== rtl/nearest_head_assign_top.sv =====
// ----------------------------------------------------------------------------
// nearest_head_assign_top: assigns a node to its nearest cluster head
// Head table loads, node queries and a head count register.
// ----------------------------------------------------------------------------
// A load word is written into the head table and gives no result. A query
// from a head, or any query while the head count is zero, is answered without
// a scan. Any other query scans the first head_count table entries, at most
// MAX_HEADS, one entry per cycle through the single read port of the head
// table, and answers from the report state once the pipeline has drained; the
// next word starts once the answer is in the output register. Words are
// accepted into a two-word queue while a search runs. The table needs no
// clearing after reset; entries must be loaded before a query searches them.
// ----------------------------------------------------------------------------
module nearest_head_assign_top #(
  parameter int MAX_HEADS  = nha_pkg::MAX_HEADS_DEF,
  parameter int COORD_BITS = nha_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nha_in_if.sink    in_ch,
  nha_out_if.source out_ch,
  nha_cfg_if.sink   cfg_ch
);

  logic                           push;
  nha_pkg::cmd_t                  push_cmd;
  logic                           q_full;
  logic                           q_valid;
  nha_pkg::cmd_t                  q_cmd;
  logic                           q_pop;
  logic [nha_pkg::COUNT_BITS-1:0] head_count;

  // accept and classify
  nha_front #(
    .MAX_HEADS (MAX_HEADS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .head_count (head_count)
  );

  // decouple front and back
  nha_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // table and search
  nha_back #(
    .MAX_HEADS  (MAX_HEADS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .head_count (head_count),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue pushed while full");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.assigned_head == '0))
    else $error("not-found result carries a head number");

  a_push_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_ch.valid && in_ch.ready))
    else $error("word queued without an accepted input");
`endif

endmodule
